// ----- design/sbpf_pkg.sv -----
package sbpf_pkg;

    localparam int MAX_BYTES   = 8;
    localparam int IDX_W       = $clog2(MAX_BYTES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] HDR_BYTE      = 8'hFF;
    localparam logic [7:0] BCAST_ID      = 8'hFE;
    localparam logic [7:0] SYNC_INSTR    = 8'h83;
    localparam logic [7:0] SYNC_DATA_LEN = 8'h02;
    localparam logic [7:0] SHORT_LEN     = 8'h02;
    localparam logic [7:0] SINGLE_EXTRA  = 8'h03;
    localparam logic [7:0] SYNC_EXTRA    = 8'h04;

    localparam logic [1:0] REQ_SINGLE = 2'd0;
    localparam logic [1:0] REQ_SYNC   = 2'd1;
    localparam logic [1:0] REQ_DATA   = 2'd2;
    localparam logic [1:0] REQ_ENTRY  = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'b001,
        KIND_SINGLE = 3'b010,
        KIND_SYNC   = 3'b100
    } kind_t;

    // One queued word: the bytes that a single input item produces.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
        logic                      ends_packet;
    } burst_t;

endpackage

// ----- design/sbpf_front.sv -----
module sbpf_front
    import sbpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_servo_id,
    input  logic [7:0]  s_instruction,
    input  logic [7:0]  s_reg_addr,
    input  logic [7:0]  s_item_count,
    input  logic [15:0] s_payload,
    input  logic        queue_full,
    output logic        push,
    output burst_t      push_burst
);

    logic [7:0] sum_reg, sum_next;
    logic [7:0] left_reg, left_next;
    kind_t      kind_reg, kind_next;
    logic       emit;
    logic [7:0] len_byte;
    logic [7:0] total;
    logic [7:0] left_dec;
    logic       accept;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && emit;

    always_comb begin
        push_burst = '0;
        emit       = 1'b0;
        sum_next   = sum_reg;
        left_next  = left_reg;
        kind_next  = kind_reg;
        len_byte   = '0;
        total      = '0;
        left_dec   = left_reg - 8'd1;
        case (s_req_type)
            REQ_SINGLE: begin
                emit = 1'b1;
                push_burst.bytes[0] = HDR_BYTE;
                push_burst.bytes[1] = HDR_BYTE;
                push_burst.bytes[2] = s_servo_id;
                push_burst.last_idx = IDX_W'(5);
                if (s_item_count == 8'd0) begin
                    total = s_servo_id + SHORT_LEN + s_instruction;
                    push_burst.bytes[3]    = SHORT_LEN;
                    push_burst.bytes[4]    = s_instruction;
                    push_burst.bytes[5]    = ~total;
                    push_burst.ends_packet = 1'b1;
                    sum_next  = '0;
                    left_next = '0;
                    kind_next = KIND_NONE;
                end else begin
                    len_byte = s_item_count + SINGLE_EXTRA;
                    total    = s_servo_id + len_byte + s_instruction + s_reg_addr;
                    push_burst.bytes[3] = len_byte;
                    push_burst.bytes[4] = s_instruction;
                    push_burst.bytes[5] = s_reg_addr;
                    sum_next  = total;
                    left_next = s_item_count;
                    kind_next = KIND_SINGLE;
                end
            end
            REQ_SYNC: begin
                emit     = 1'b1;
                len_byte = {s_item_count[6:0], 1'b0} + s_item_count + SYNC_EXTRA;
                total    = BCAST_ID + len_byte + SYNC_INSTR + s_reg_addr + SYNC_DATA_LEN;
                push_burst.bytes[0] = HDR_BYTE;
                push_burst.bytes[1] = HDR_BYTE;
                push_burst.bytes[2] = BCAST_ID;
                push_burst.bytes[3] = len_byte;
                push_burst.bytes[4] = SYNC_INSTR;
                push_burst.bytes[5] = s_reg_addr;
                push_burst.bytes[6] = SYNC_DATA_LEN;
                if (s_item_count == 8'd0) begin
                    push_burst.bytes[7]    = ~total;
                    push_burst.last_idx    = IDX_W'(7);
                    push_burst.ends_packet = 1'b1;
                    sum_next  = '0;
                    left_next = '0;
                    kind_next = KIND_NONE;
                end else begin
                    push_burst.last_idx = IDX_W'(6);
                    sum_next  = total;
                    left_next = s_item_count;
                    kind_next = KIND_SYNC;
                end
            end
            REQ_DATA: begin
                if (kind_reg == KIND_SINGLE) begin
                    emit  = 1'b1;
                    total = sum_reg + s_payload[7:0];
                    push_burst.bytes[0] = s_payload[7:0];
                    if (left_dec == 8'd0) begin
                        push_burst.bytes[1]    = ~total;
                        push_burst.last_idx    = IDX_W'(1);
                        push_burst.ends_packet = 1'b1;
                        sum_next  = '0;
                        left_next = '0;
                        kind_next = KIND_NONE;
                    end else begin
                        sum_next  = total;
                        left_next = left_dec;
                    end
                end
            end
            REQ_ENTRY: begin
                if (kind_reg == KIND_SYNC) begin
                    emit  = 1'b1;
                    total = sum_reg + s_servo_id + s_payload[15:8] + s_payload[7:0];
                    push_burst.bytes[0] = s_servo_id;
                    push_burst.bytes[1] = s_payload[15:8];
                    push_burst.bytes[2] = s_payload[7:0];
                    if (left_dec == 8'd0) begin
                        push_burst.bytes[3]    = ~total;
                        push_burst.last_idx    = IDX_W'(3);
                        push_burst.ends_packet = 1'b1;
                        sum_next  = '0;
                        left_next = '0;
                        kind_next = KIND_NONE;
                    end else begin
                        push_burst.last_idx = IDX_W'(2);
                        sum_next  = total;
                        left_next = left_dec;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            left_reg <= '0;
            kind_reg <= KIND_NONE;
        end else if (accept) begin
            sum_reg  <= sum_next;
            left_reg <= left_next;
            kind_reg <= kind_next;
        end
    end

endmodule

// ----- design/sbpf_queue.sv -----
module sbpf_queue
    import sbpf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  burst_t push_burst,
    output logic   full,
    input  logic   pop,
    output burst_t head,
    output logic   empty
);

    burst_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_burst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/sbpf_back.sv -----
module sbpf_back
    import sbpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  burst_t     head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_packet_byte,
    output logic       m_run_last,
    output logic       m_packet_end
);

    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             run_last_reg;
    logic             end_reg;
    logic             load;
    logic             at_last;

    assign load    = !empty && (!valid_reg || m_ready);
    assign at_last = (idx_reg == head.last_idx);
    assign pop     = load && at_last;

    assign m_valid       = valid_reg;
    assign m_packet_byte = byte_reg;
    assign m_run_last    = run_last_reg;
    assign m_packet_end  = end_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg     <= head.bytes[idx_reg];
            run_last_reg <= at_last;
            end_reg      <= at_last && head.ends_packet;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? '0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/servo_bus_packet_framer_top.sv -----
// Servo bus packet framer. Each accepted request word turns into one to eight bus bytes,
// delivered one per cycle while m_ready is high; requests that arrive with no matching
// packet open are accepted and produce nothing. The front end classifies a request and
// builds its bytes, including the running checksum, in the cycle it is accepted, and
// hands them to a four-entry queue, so s_ready stays high while the queue has room even
// when the result side stalls. The output serializer sets the sustained rate: it sends a
// request's bytes one at a time (six for a single start, seven or eight for a sync start,
// one or two for a data byte, three or four for a sync entry).
module servo_bus_packet_framer_top
    import sbpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_servo_id,
    input  logic [7:0]  s_instruction,
    input  logic [7:0]  s_reg_addr,
    input  logic [7:0]  s_item_count,
    input  logic [15:0] s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_packet_byte,
    output logic        m_run_last,
    output logic        m_packet_end
);

    logic   push;
    burst_t push_burst;
    logic   full;
    logic   pop;
    burst_t head;
    logic   empty;

    sbpf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_servo_id    (s_servo_id),
        .s_instruction (s_instruction),
        .s_reg_addr    (s_reg_addr),
        .s_item_count  (s_item_count),
        .s_payload     (s_payload),
        .queue_full    (full),
        .push          (push),
        .push_burst    (push_burst)
    );

    sbpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_burst (push_burst),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    sbpf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packet_byte (m_packet_byte),
        .m_run_last    (m_run_last),
        .m_packet_end  (m_packet_end)
    );

endmodule
